### hw/rtl/ppta_pkg.sv
package ppta_pkg;

  localparam int ACTION_W = 2;
  localparam int REQ_W    = 3;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_BEGIN = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_END   = 2'd1;

  localparam logic [STATUS_W-1:0] STAT_ACK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NACK    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

  localparam logic KIND_PREEMPTED = 1'b0;
  localparam logic KIND_GRANTED   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic exec;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dp_status_t;

endpackage

### hw/rtl/ppta_ctrl.sv
module ppta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ppta_pkg::dp_status_t dp_stat,
  output ppta_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                out_valid
);

  ppta_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppta_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ppta_pkg::S_IDLE, ppta_pkg::S_RESP: begin
        out_valid = (state_r == ppta_pkg::S_RESP);
        state_nxt = ppta_pkg::S_IDLE;
        if (start) begin
          cmd.exec  = 1'b1;
          state_nxt = dp_stat.need_scan ? ppta_pkg::S_SCAN : ppta_pkg::S_RESP;
        end
      end
      ppta_pkg::S_SCAN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (dp_stat.scan_last) begin
          state_nxt = ppta_pkg::S_RESP;
        end
      end
      default: begin
        state_nxt = ppta_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/ppta_datapath.sv
module ppta_datapath #(
  parameter int NUM_REQUESTERS = 6,
  parameter int TOP_PRIORITY   = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ppta_pkg::ctrl_cmd_t              cmd,
  output ppta_pkg::dp_status_t             dp_stat,
  input  logic [ppta_pkg::ACTION_W-1:0]    in_action,
  input  logic [ppta_pkg::REQ_W-1:0]       in_requester,
  input  logic [ppta_pkg::PRIO_W-1:0]      in_request_priority,
  output logic [ppta_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_notify_valid,
  output logic [ppta_pkg::REQ_W-1:0]       out_notify_target,
  output logic                             out_notify_kind,
  output logic                             out_holder_valid,
  output logic [ppta_pkg::REQ_W-1:0]       out_holder
);

  localparam int CNT_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;

  logic [ppta_pkg::PRIO_W-1:0] pending_r [NUM_REQUESTERS];
  logic [ppta_pkg::PRIO_W-1:0] pending_nxt [NUM_REQUESTERS];

  logic [ppta_pkg::REQ_W-1:0]  holder_idx_r, holder_idx_nxt;
  logic                        holder_present_r, holder_present_nxt;
  logic [ppta_pkg::PRIO_W-1:0] holder_level_r, holder_level_nxt;

  logic [CNT_W-1:0]            scan_idx_r, scan_idx_nxt;
  logic [ppta_pkg::PRIO_W-1:0] best_level_r, best_level_nxt;
  logic [ppta_pkg::REQ_W-1:0]  best_idx_r, best_idx_nxt;
  logic                        best_found_r, best_found_nxt;

  logic [ppta_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                          nvalid_r, nvalid_nxt;
  logic [ppta_pkg::REQ_W-1:0]    ntarget_r, ntarget_nxt;
  logic                          nkind_r, nkind_nxt;

  logic                        in_range;
  logic                        is_holder;
  logic [ppta_pkg::PRIO_W-1:0] prio_sat;
  logic [ppta_pkg::PRIO_W-1:0] cand;
  logic                        better;

  assign in_range  = (32'(in_requester) < NUM_REQUESTERS);
  assign is_holder = holder_present_r && (holder_idx_r == in_requester);
  assign prio_sat  = (32'(in_request_priority) > TOP_PRIORITY) ?
                     ppta_pkg::PRIO_W'(TOP_PRIORITY) : in_request_priority;
  assign cand      = pending_r[scan_idx_r];
  assign better    = cand > best_level_r;

  assign dp_stat.need_scan = (in_action == ppta_pkg::ACT_END) && in_range && is_holder;
  assign dp_stat.scan_last = (scan_idx_r == CNT_W'(NUM_REQUESTERS - 1));

  always_comb begin
    pending_nxt        = pending_r;
    holder_idx_nxt     = holder_idx_r;
    holder_present_nxt = holder_present_r;
    holder_level_nxt   = holder_level_r;
    scan_idx_nxt       = scan_idx_r;
    best_level_nxt     = best_level_r;
    best_idx_nxt       = best_idx_r;
    best_found_nxt     = best_found_r;
    status_nxt         = status_r;
    nvalid_nxt         = nvalid_r;
    ntarget_nxt        = ntarget_r;
    nkind_nxt          = nkind_r;

    if (cmd.exec) begin
      status_nxt     = ppta_pkg::STAT_ACK;
      nvalid_nxt     = 1'b0;
      ntarget_nxt    = '0;
      nkind_nxt      = ppta_pkg::KIND_PREEMPTED;
      scan_idx_nxt   = '0;
      best_level_nxt = '0;
      best_idx_nxt   = '0;
      best_found_nxt = 1'b0;
      unique case (in_action)
        ppta_pkg::ACT_BEGIN: begin
          if (in_range) begin
            for (int i = 0; i < NUM_REQUESTERS; i++) begin
              if (32'(in_requester) == i) begin
                pending_nxt[i] = prio_sat;
              end
            end
            if (prio_sat > holder_level_r) begin
              if (holder_present_r && (holder_idx_r != in_requester)) begin
                nvalid_nxt  = 1'b1;
                ntarget_nxt = holder_idx_r;
                nkind_nxt   = ppta_pkg::KIND_PREEMPTED;
              end
              holder_idx_nxt     = in_requester;
              holder_present_nxt = 1'b1;
              holder_level_nxt   = prio_sat;
              status_nxt         = ppta_pkg::STAT_ACK;
            end else begin
              status_nxt = is_holder ? ppta_pkg::STAT_ACK : ppta_pkg::STAT_NACK;
            end
          end else begin
            status_nxt = ppta_pkg::STAT_NACK;
          end
        end
        ppta_pkg::ACT_END: begin
          if (in_range) begin
            for (int i = 0; i < NUM_REQUESTERS; i++) begin
              if (32'(in_requester) == i) begin
                pending_nxt[i] = '0;
              end
            end
          end
        end
        default: begin
          status_nxt = ppta_pkg::STAT_INVALID;
        end
      endcase
    end else if (cmd.step) begin
      if (better) begin
        best_level_nxt = cand;
        best_idx_nxt   = ppta_pkg::REQ_W'(scan_idx_r);
        best_found_nxt = 1'b1;
      end
      scan_idx_nxt = scan_idx_r + 1'b1;
      if (dp_stat.scan_last) begin
        holder_present_nxt = best_found_nxt;
        holder_idx_nxt     = best_idx_nxt;
        holder_level_nxt   = best_level_nxt;
        status_nxt         = ppta_pkg::STAT_ACK;
        nvalid_nxt         = best_found_nxt;
        ntarget_nxt        = best_idx_nxt;
        nkind_nxt          = best_found_nxt ? ppta_pkg::KIND_GRANTED
                                            : ppta_pkg::KIND_PREEMPTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REQUESTERS; i++) begin
        pending_r[i] <= '0;
      end
      holder_idx_r     <= '0;
      holder_present_r <= 1'b0;
      holder_level_r   <= '0;
      scan_idx_r       <= '0;
    end else begin
      pending_r        <= pending_nxt;
      holder_idx_r     <= holder_idx_nxt;
      holder_present_r <= holder_present_nxt;
      holder_level_r   <= holder_level_nxt;
      scan_idx_r       <= scan_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_level_r <= best_level_nxt;
    best_idx_r   <= best_idx_nxt;
    best_found_r <= best_found_nxt;
    status_r     <= status_nxt;
    nvalid_r     <= nvalid_nxt;
    ntarget_r    <= ntarget_nxt;
    nkind_r      <= nkind_nxt;
  end

  assign out_status        = status_r;
  assign out_notify_valid  = nvalid_r;
  assign out_notify_target = ntarget_r;
  assign out_notify_kind   = nkind_r;
  assign out_holder_valid  = holder_present_r;
  assign out_holder        = holder_present_r ? holder_idx_r : '0;

endmodule

### hw/rtl/preemptive_priority_token_arbiter_unit.sv
// Begin, invalid, and end by a non-holder: result strobes in the cycle after acceptance;
// a new request may be accepted in that same cycle (one request per cycle).
// End by the holder: busy while the scan unit reads one pending entry per cycle, from
// index 0 up to NUM_REQUESTERS - 1; the result strobes once the last entry has been read.
// Synchronous active-low reset clears all pending requests and frees the token.
// Results cannot be stalled: out_valid is high for exactly one cycle per request.
module preemptive_priority_token_arbiter_unit #(
  parameter int NUM_REQUESTERS = 6,
  parameter int TOP_PRIORITY   = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ppta_pkg::ACTION_W-1:0]    in_action,
  input  logic [ppta_pkg::REQ_W-1:0]       in_requester,
  input  logic [ppta_pkg::PRIO_W-1:0]      in_request_priority,
  output logic                             out_valid,
  output logic [ppta_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_notify_valid,
  output logic [ppta_pkg::REQ_W-1:0]       out_notify_target,
  output logic                             out_notify_kind,
  output logic                             out_holder_valid,
  output logic [ppta_pkg::REQ_W-1:0]       out_holder
);

  ppta_pkg::ctrl_cmd_t  cmd;
  ppta_pkg::dp_status_t dp_stat;

  ppta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_stat   (dp_stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ppta_datapath #(
    .NUM_REQUESTERS (NUM_REQUESTERS),
    .TOP_PRIORITY   (TOP_PRIORITY)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .dp_stat             (dp_stat),
    .in_action           (in_action),
    .in_requester        (in_requester),
    .in_request_priority (in_request_priority),
    .out_status          (out_status),
    .out_notify_valid    (out_notify_valid),
    .out_notify_target   (out_notify_target),
    .out_notify_kind     (out_notify_kind),
    .out_holder_valid    (out_holder_valid),
    .out_holder          (out_holder)
  );

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request did not advance");

  a_grant_is_holder: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notify_valid && (out_notify_kind == ppta_pkg::KIND_GRANTED))
    |-> (out_holder_valid && (out_holder == out_notify_target)))
    else $error("granted target is not the holder");

  a_preempt_not_holder: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notify_valid && (out_notify_kind == ppta_pkg::KIND_PREEMPTED))
    |-> (out_holder_valid && (out_holder != out_notify_target)))
    else $error("preempted target still holds the token");

  a_exec_not_while_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.step))
    else $error("exec and scan step together");

endmodule

### tb/token_grant_checker.sv
`timescale 1ns / 1ps

module token_grant_checker #(
  parameter int NUM_REQUESTERS = 6,
  parameter int TOP_PRIORITY   = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [ppta_pkg::ACTION_W-1:0] in_action,
  input  logic [ppta_pkg::REQ_W-1:0]    in_requester,
  input  logic [ppta_pkg::PRIO_W-1:0]   in_request_priority,
  input  logic                          out_valid,
  input  logic [ppta_pkg::STATUS_W-1:0] out_status,
  input  logic                          out_notify_valid,
  input  logic [ppta_pkg::REQ_W-1:0]    out_notify_target,
  input  logic                          out_notify_kind,
  input  logic                          out_holder_valid,
  input  logic [ppta_pkg::REQ_W-1:0]    out_holder,
  output int                            failures,
  output int                            outstanding
);

  typedef struct packed {
    logic [ppta_pkg::STATUS_W-1:0] status;
    logic                          notify_valid;
    logic [ppta_pkg::REQ_W-1:0]    notify_target;
    logic                          notify_kind;
    logic                          holder_valid;
    logic [ppta_pkg::REQ_W-1:0]    holder;
  } grant_resp_t;

  logic [ppta_pkg::PRIO_W-1:0] pend_prio [NUM_REQUESTERS];
  logic [ppta_pkg::REQ_W-1:0]  tok_owner;
  logic                        tok_held;
  logic [ppta_pkg::PRIO_W-1:0] tok_level;

  grant_resp_t expected_grants [$];

  task automatic arbitrate(input logic [ppta_pkg::ACTION_W-1:0] act,
                           input logic [ppta_pkg::REQ_W-1:0] req,
                           input logic [ppta_pkg::PRIO_W-1:0] prio_in,
                           output grant_resp_t r);
    logic [ppta_pkg::PRIO_W-1:0] prio;
    logic                        in_range;
    r = '0;
    r.status = ppta_pkg::STAT_ACK;
    r.notify_kind = ppta_pkg::KIND_PREEMPTED;
    in_range = (req < NUM_REQUESTERS);
    prio = (prio_in > TOP_PRIORITY) ? ppta_pkg::PRIO_W'(TOP_PRIORITY) : prio_in;
    if (act == ppta_pkg::ACT_BEGIN) begin
      if (in_range) begin
        pend_prio[req] = prio;
        if (prio > tok_level) begin
          if (tok_held && tok_owner != req) begin
            r.notify_valid = 1'b1;
            r.notify_target = tok_owner;
            r.notify_kind = ppta_pkg::KIND_PREEMPTED;
          end
          tok_owner = req;
          tok_held = 1'b1;
          tok_level = prio;
        end
        r.status = (tok_held && tok_owner == req) ? ppta_pkg::STAT_ACK : ppta_pkg::STAT_NACK;
      end else begin
        r.status = ppta_pkg::STAT_NACK;
      end
    end else if (act == ppta_pkg::ACT_END) begin
      if (in_range) begin
        pend_prio[req] = '0;
        if (tok_held && tok_owner == req) begin
          // hand off to highest pending, lowest index on ties
          tok_held = 1'b0;
          tok_owner = '0;
          tok_level = '0;
          for (int i = 0; i < NUM_REQUESTERS; i++) begin
            if (pend_prio[i] > tok_level) begin
              tok_level = pend_prio[i];
              tok_owner = ppta_pkg::REQ_W'(i);
              tok_held = 1'b1;
            end
          end
          if (tok_held) begin
            r.notify_valid = 1'b1;
            r.notify_target = tok_owner;
            r.notify_kind = ppta_pkg::KIND_GRANTED;
          end
        end
      end
      r.status = ppta_pkg::STAT_ACK;
    end else begin
      r.status = ppta_pkg::STAT_INVALID;
    end
    r.holder_valid = tok_held;
    r.holder = tok_held ? tok_owner : '0;
  endtask

  task automatic report_field(input string fname, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    grant_resp_t exp_r;
    grant_resp_t new_r;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REQUESTERS; i++) pend_prio[i] = '0;
      tok_owner = '0;
      tok_held = 1'b0;
      tok_level = '0;
      failures = 0;
      expected_grants.delete();
    end else begin
      // results never strobe in the same cycle as their request, so compare first
      if (out_valid) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d holder %0d",
                   $time, out_status, out_holder);
          failures++;
        end else begin
          exp_r = expected_grants.pop_front();
          report_field("status", exp_r.status, out_status);
          report_field("notify_valid", exp_r.notify_valid, out_notify_valid);
          report_field("notify_target", exp_r.notify_target, out_notify_target);
          report_field("notify_kind", exp_r.notify_kind, out_notify_kind);
          report_field("holder_valid", exp_r.holder_valid, out_holder_valid);
          report_field("holder", exp_r.holder, out_holder);
        end
      end
      if (start && !busy) begin
        arbitrate(in_action, in_requester, in_request_priority, new_r);
        expected_grants.push_back(new_r);
      end
    end
    outstanding = expected_grants.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NUM_REQ      = 6;
  localparam int TOP_PRIO     = 6;
  localparam int RANDOM_ITEMS = 1350;
  localparam int QUIET_LIMIT  = 1000;

  localparam logic [ppta_pkg::ACTION_W-1:0] ACT_BAD_LO = 2'd2;
  localparam logic [ppta_pkg::ACTION_W-1:0] ACT_BAD_HI = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [ppta_pkg::ACTION_W-1:0] in_action;
  logic [ppta_pkg::REQ_W-1:0]    in_requester;
  logic [ppta_pkg::PRIO_W-1:0]   in_request_priority;
  logic                          out_valid;
  logic [ppta_pkg::STATUS_W-1:0] out_status;
  logic                          out_notify_valid;
  logic [ppta_pkg::REQ_W-1:0]    out_notify_target;
  logic                          out_notify_kind;
  logic                          out_holder_valid;
  logic [ppta_pkg::REQ_W-1:0]    out_holder;
  int                            failures;
  int                            outstanding;
  int                            quiet_cycles;

  preemptive_priority_token_arbiter_unit #(
    .NUM_REQUESTERS(NUM_REQ),
    .TOP_PRIORITY(TOP_PRIO)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_requester(in_requester),
    .in_request_priority(in_request_priority),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_notify_valid(out_notify_valid),
    .out_notify_target(out_notify_target),
    .out_notify_kind(out_notify_kind),
    .out_holder_valid(out_holder_valid),
    .out_holder(out_holder)
  );

  token_grant_checker #(
    .NUM_REQUESTERS(NUM_REQ),
    .TOP_PRIORITY(TOP_PRIO)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_requester(in_requester),
    .in_request_priority(in_request_priority),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_notify_valid(out_notify_valid),
    .out_notify_target(out_notify_target),
    .out_notify_kind(out_notify_kind),
    .out_holder_valid(out_holder_valid),
    .out_holder(out_holder),
    .failures(failures),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [ppta_pkg::ACTION_W-1:0] act,
                              input logic [ppta_pkg::REQ_W-1:0] req,
                              input logic [ppta_pkg::PRIO_W-1:0] prio);
    @(negedge clk);
    start <= 1'b1;
    in_action <= act;
    in_requester <= req;
    in_request_priority <= prio;
    do @(posedge clk); while (busy);
  endtask

  task automatic go_idle(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain;
    go_idle(1);
    wait (outstanding == 0);
  endtask

  initial begin
    int burst_left;
    int pick;
    logic [ppta_pkg::ACTION_W-1:0] act;
    logic [ppta_pkg::REQ_W-1:0]    req;
    logic [ppta_pkg::PRIO_W-1:0]   prio;

    start <= 1'b0;
    in_action <= ppta_pkg::ACT_BEGIN;
    in_requester <= '0;
    in_request_priority <= '0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero priority, re-begin, ties, saturation, preemption,
    // out-of-range requesters, invalid actions, hand-offs and freeing the token
    send_request(ppta_pkg::ACT_BEGIN, 3'd0, 3'd0);
    send_request(ppta_pkg::ACT_BEGIN, 3'd0, 3'd3);
    send_request(ppta_pkg::ACT_BEGIN, 3'd0, 3'd2);
    send_request(ppta_pkg::ACT_BEGIN, 3'd0, 3'd5);
    send_request(ppta_pkg::ACT_BEGIN, 3'd1, 3'd5);
    send_request(ppta_pkg::ACT_BEGIN, 3'd2, 3'd7);
    send_request(ppta_pkg::ACT_BEGIN, 3'd5, 3'd6);
    send_request(ppta_pkg::ACT_BEGIN, ppta_pkg::REQ_W'(NUM_REQ), 3'd4);
    send_request(ppta_pkg::ACT_END, ppta_pkg::REQ_W'(NUM_REQ + 1), 3'd0);
    send_request(ACT_BAD_LO, 3'd2, 3'd1);
    send_request(ACT_BAD_HI, 3'd7, 3'd7);
    send_request(ppta_pkg::ACT_END, 3'd1, 3'd0);
    send_request(ppta_pkg::ACT_END, 3'd2, 3'd0);
    send_request(ppta_pkg::ACT_BEGIN, 3'd3, 3'd6);
    send_request(ppta_pkg::ACT_END, 3'd5, 3'd0);
    send_request(ppta_pkg::ACT_BEGIN, 3'd4, 3'd1);
    send_request(ppta_pkg::ACT_END, 3'd3, 3'd0);
    send_request(ppta_pkg::ACT_BEGIN, 3'd0, 3'd0);
    send_request(ppta_pkg::ACT_END, 3'd0, 3'd0);
    send_request(ppta_pkg::ACT_END, 3'd4, 3'd0);
    send_request(ppta_pkg::ACT_END, 3'd4, 3'd0);
    send_request(ppta_pkg::ACT_BEGIN, 3'd5, 3'd7);
    send_request(ppta_pkg::ACT_END, 3'd5, 3'd0);
    drain();

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        drain();
        burst_left = 0;
      end
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 10));
        burst_left = $urandom_range(1, 24);
      end
      pick = $urandom_range(0, 99);
      if (pick < 48) act = ppta_pkg::ACT_BEGIN;
      else if (pick < 88) act = ppta_pkg::ACT_END;
      else act = $urandom_range(0, 1) ? ACT_BAD_HI : ACT_BAD_LO;
      if ($urandom_range(0, 99) < 90) req = ppta_pkg::REQ_W'($urandom_range(0, NUM_REQ - 1));
      else req = ppta_pkg::REQ_W'($urandom_range(NUM_REQ, 7));
      if ($urandom_range(0, 99) < 85) prio = ppta_pkg::PRIO_W'($urandom_range(1, TOP_PRIO));
      else prio = $urandom_range(0, 1) ? 3'd7 : 3'd0;
      send_request(act, req, prio);
      burst_left--;
    end

    drain();
    repeat (NUM_REQ + 4) @(posedge clk);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
